// ----- design/llur_pkg.sv -----
package llur_pkg;

   localparam int NUM_UNITS   = 8;
   localparam int CFG_COUNT   = 8;
   localparam int UNIT_W      = 3;
   localparam int POOL_W      = 8;
   localparam int CYCLE_W     = 48;
   localparam int DUR_W       = 32;
   localparam int BYTES_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [STATUS_W-1:0] ST_GRANT   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASE = 2'd3;

   localparam logic KIND_RESERVE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [CYCLE_W-1:0] CYCLE_SAT = '1;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   typedef logic [NUM_UNITS-1:0][BYTES_W-1:0] bytes_vec_type;
   typedef logic [NUM_UNITS-1:0][CYCLE_W-1:0] cycle_vec_type;
   typedef logic [CFG_COUNT-1:0][BYTES_W-1:0] cap_vec_type;

   typedef struct packed {
      logic               found;
      logic [UNIT_W-1:0]  unit;
      logic [CYCLE_W-1:0] start;
      logic [BYTES_W-1:0] used;
   } pick_type;

endpackage

// ----- design/llur_req_if.sv -----
interface llur_req_if
   import llur_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [POOL_W-1:0]  pool_mask;
   logic [CYCLE_W-1:0] now_cycle;
   logic [DUR_W-1:0]   duration;
   logic [BYTES_W-1:0] request_bytes;
   logic [UNIT_W-1:0]  unit_index;

   modport source (output valid, kind, pool_mask, now_cycle, duration, request_bytes,
                   unit_index, input ready);
   modport sink   (input valid, kind, pool_mask, now_cycle, duration, request_bytes,
                   unit_index, output ready);
endinterface

// ----- design/llur_rsp_if.sv -----
interface llur_rsp_if
   import llur_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [UNIT_W-1:0]   chosen_unit;
   logic [CYCLE_W-1:0]  start_cycle;
   logic [BYTES_W-1:0]  used_after;

   modport source (output valid, status, chosen_unit, start_cycle, used_after, input ready);
   modport sink   (input valid, status, chosen_unit, start_cycle, used_after, output ready);
endinterface

// ----- design/llur_select.sv -----
module llur_select
   import llur_pkg::*;
(
   input  logic [POOL_W-1:0]  pool_mask,
   input  logic [CYCLE_W-1:0] now_cycle,
   input  logic [BYTES_W-1:0] request_bytes,
   input  bytes_vec_type      used_vec,
   input  cycle_vec_type      busy_vec,
   input  cap_vec_type        cap_vec,
   output pick_type           pick
);

   function automatic pick_type pick_min(input pick_type a, input pick_type b);
      pick_type r;
      // ties keep the left side, which has the lower unit index
      if (b.found && (!a.found || {b.used, b.start} < {a.used, a.start})) begin
         r = b;
      end else begin
         r = a;
      end
      return r;
   endfunction

   pick_type          leaf [POOL_W];
   pick_type          lvl1 [POOL_W/2];
   pick_type          lvl2 [POOL_W/4];
   logic [BYTES_W:0]  sum;
   logic              fits;

   always_comb begin
      for (int i = 0; i < POOL_W; i++) begin
         leaf[i] = '0;
         sum     = '0;
         fits    = 1'b0;
         if (i < NUM_UNITS) begin
            sum  = {1'b0, used_vec[i]} + {1'b0, request_bytes};
            // zero capacity means no limit
            fits = (cap_vec[i] == '0) || (sum <= {1'b0, cap_vec[i]});
            leaf[i].found = pool_mask[i] && fits;
            leaf[i].unit  = UNIT_W'(i);
            leaf[i].start = (now_cycle > busy_vec[i]) ? now_cycle : busy_vec[i];
            leaf[i].used  = used_vec[i];
         end
      end
      for (int k = 0; k < POOL_W/2; k++) begin
         lvl1[k] = pick_min(leaf[2*k], leaf[2*k+1]);
      end
      for (int k = 0; k < POOL_W/4; k++) begin
         lvl2[k] = pick_min(lvl1[2*k], lvl1[2*k+1]);
      end
      pick = pick_min(lvl2[0], lvl2[1]);
   end

endmodule

// ----- design/least_loaded_unit_reserver.sv -----
// a transaction accepted into the input register has its result registered when it advances
// throughput: one transaction per cycle unless the result stalls; the per-unit state is read and
//   written back in the single stage between the input register and the result register
// reset: synchronous, active high; clears busy-until, bytes in use, all capacities and valids
module least_loaded_unit_reserver
   import llur_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   llur_req_if.sink               req_chan,
   llur_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic               in_vld_ff;
   logic               in_kind_ff;
   logic [POOL_W-1:0]  in_mask_ff;
   logic [CYCLE_W-1:0] in_now_ff;
   logic [DUR_W-1:0]   in_dur_ff;
   logic [BYTES_W-1:0] in_req_ff;
   logic [UNIT_W-1:0]  in_unit_ff;

   logic                out_vld_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [UNIT_W-1:0]   out_unit_ff;
   logic [CYCLE_W-1:0]  out_start_ff;
   logic [BYTES_W-1:0]  out_used_ff;

   cap_vec_type   cap_ff;
   bytes_vec_type used_ff;
   cycle_vec_type busy_ff;

   logic                advance;
   pick_type            pick;
   logic [CYCLE_W:0]    end_sum;
   logic [BYTES_W:0]    used_sum;
   logic [CYCLE_W-1:0]  end_in;
   logic [BYTES_W-1:0]  grant_used_in;
   logic [BYTES_W-1:0]  rel_used_in;
   logic                rel_ok;
   logic [STATUS_W-1:0] status_in;
   logic [UNIT_W-1:0]   unit_in;
   logic [CYCLE_W-1:0]  start_in;
   logic [BYTES_W-1:0]  used_in;

   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.chosen_unit = out_unit_ff;
   assign rsp_chan.start_cycle = out_start_ff;
   assign rsp_chan.used_after  = out_used_ff;

   llur_select u_select (
      .pool_mask     (in_mask_ff),
      .now_cycle     (in_now_ff),
      .request_bytes (in_req_ff),
      .used_vec      (used_ff),
      .busy_vec      (busy_ff),
      .cap_vec       (cap_ff),
      .pick          (pick)
   );

   always_comb begin
      end_sum       = {1'b0, pick.start} + {{(CYCLE_W-DUR_W+1){1'b0}}, in_dur_ff};
      end_in        = end_sum[CYCLE_W] ? CYCLE_SAT : end_sum[CYCLE_W-1:0];
      used_sum      = {1'b0, pick.used} + {1'b0, in_req_ff};
      grant_used_in = used_sum[BYTES_W] ? BYTES_MAX : used_sum[BYTES_W-1:0];
      rel_ok        = (int'(in_unit_ff) < NUM_UNITS);
      rel_used_in   = '0;
      if (rel_ok && (in_req_ff <= used_ff[in_unit_ff])) begin
         rel_used_in = used_ff[in_unit_ff] - in_req_ff;
      end

      status_in = ST_GRANT;
      unit_in   = '0;
      start_in  = '0;
      used_in   = '0;
      if (in_kind_ff == KIND_RELEASE) begin
         status_in = ST_RELEASE;
         unit_in   = in_unit_ff;
         used_in   = rel_used_in;
      end else if (in_mask_ff == '0) begin
         status_in = ST_EMPTY;
      end else if (!pick.found) begin
         status_in = ST_NOFIT;
      end else begin
         unit_in  = pick.unit;
         start_in = pick.start;
         used_in  = grant_used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_kind_ff <= req_chan.kind;
         in_mask_ff <= req_chan.pool_mask;
         in_now_ff  <= req_chan.now_cycle;
         in_dur_ff  <= req_chan.duration;
         in_req_ff  <= req_chan.request_bytes;
         in_unit_ff <= req_chan.unit_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
      if (advance) begin
         out_status_ff <= status_in;
         out_unit_ff   <= unit_in;
         out_start_ff  <= start_in;
         out_used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else if (csr_we && (int'(csr_index) < CFG_COUNT)) begin
         cap_ff[csr_index] <= csr_wdata[BYTES_W-1:0];
      end
   end

   // unit state is written back in the same cycle the result is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         busy_ff <= '0;
      end else if (advance) begin
         if (in_kind_ff == KIND_RELEASE) begin
            if (rel_ok) begin
               used_ff[in_unit_ff] <= rel_used_in;
            end
         end else if ((in_mask_ff != '0) && pick.found) begin
            used_ff[pick.unit] <= grant_used_in;
            busy_ff[pick.unit] <= end_in;
         end
      end
   end

endmodule

// ----- design/llur_checker.sv -----
module llur_checker
   import llur_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [UNIT_W-1:0]   rsp_chosen_unit,
   input logic [CYCLE_W-1:0]  rsp_start_cycle,
   input logic [BYTES_W-1:0]  rsp_used_after
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_chosen_unit) && $stable(rsp_start_cycle) && $stable(rsp_used_after))
      else $error("result changed while stalled");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_start_only_on_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_GRANT) |-> rsp_start_cycle == '0)
      else $error("start cycle on a non-grant result");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_EMPTY) || (rsp_status == ST_NOFIT))
         |-> (rsp_chosen_unit == '0) && (rsp_used_after == '0))
      else $error("error result carries unit or byte count");

endmodule

bind least_loaded_unit_reserver llur_checker u_llur_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_chosen_unit (rsp_chan.chosen_unit),
   .rsp_start_cycle (rsp_chan.start_cycle),
   .rsp_used_after  (rsp_chan.used_after)
);
